[src/huffman_code_length_builder_unit_assert.svh]
// ----------------------------------------------------------------------------
// hclb assertion macros
// shared concurrent check macros for the code length builder
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_LENGTH_BUILDER_UNIT_ASSERT_SVH
`define HUFFMAN_CODE_LENGTH_BUILDER_UNIT_ASSERT_SVH

// implication check, disabled while in reset
`define HCLB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hclb implication check failed");

// invariant check, disabled while in reset
`define HCLB_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("hclb invariant check failed");

`endif

[src/hclb_pkg.sv]
// ----------------------------------------------------------------------------
// hclb package
// widths, codes and entry type of the code length builder
// ----------------------------------------------------------------------------
`default_nettype none
package hclb_pkg;
  localparam int ALPHABET   = 256;
  localparam int MAX_LENGTH = 24;
  localparam int AW = 8;   // symbol / address width
  localparam int CW = 9;   // count width, holds ALPHABET
  localparam int FW = 31;  // frequency width
  localparam int WW = 40;  // node weight width, no wrap over ALPHABET sums
  localparam int LW = 5;   // code length width

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_READ     = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [AW-1:0] sym;
    logic [FW-1:0] freq;
  } ent_t;
endpackage
`default_nettype wire

[src/hclb_ram.sv]
// ----------------------------------------------------------------------------
// hclb ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module hclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/huffman_code_length_builder_unit.sv]
// ----------------------------------------------------------------------------
// huffman code length builder unit
// in-place huffman code length construction over a 256 symbol alphabet
// ----------------------------------------------------------------------------
// A load request writes one frequency. A load marked last starts a build,
// a read request returns one stored code length. The build runs under one
// sequencer over memories with one write port and one registered read port:
// a scan of all 256 frequency entries (also clearing the lengths), an
// insertion sort of the n used symbols, a copy, the pairing pass, the depth
// pass, a length check, a length write (skipped when the check fails) and a
// clearing sweep of the frequency store. The frequency memory port and the
// sort loop set the build time. After reset a clearing pass zeroes the
// frequency and length stores before the first request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module huffman_code_length_builder_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   operation,
  input  wire logic [hclb_pkg::AW-1:0] symbol,
  input  wire logic [hclb_pkg::FW-1:0] frequency,
  input  wire logic                   last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        kind,
  output logic [hclb_pkg::AW-1:0]     symbol_out,
  output logic [hclb_pkg::LW-1:0]     code_length,
  output logic                        status,
  output logic [hclb_pkg::CW-1:0]     used_symbols
);
  import hclb_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_SCAN,
    S_SORT_A, S_SORT_B, S_SORT_C, S_SORT_D,
    S_COPY, S_P0, S_P1, S_P2, S_P3,
    S_D0, S_DK, S_D1, S_D2, S_D3,
    S_CHK, S_WR
  } state_t;

  state_t state;

  // sequencer registers
  logic [CW-1:0]   idx, n, a, b, s, r, t, top, k, i, depth, guard, inner;
  logic [AW-1:0]   paddr;
  logic            pv, kk, fail, one, rst_clr;
  logic [WW-1:0]   sum, wr;
  logic [CW:0]     nodes;
  logic signed [CW+1:0] cnt;
  ent_t            key;

  // memory ports
  logic            f_we, s_we, w_we, l_we;
  logic [AW-1:0]   f_wa, f_ra, s_wa, s_ra, w_wa, w_ra, l_wa, l_ra;
  logic [FW-1:0]   f_wd, f_rd;
  ent_t            s_wd, s_rd;
  logic [WW-1:0]   w_wd, w_rd;
  logic [LW-1:0]   l_wd, l_rd;

  logic            acc, take, bad;
  logic [WW-1:0]   sum_add;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc      = in_valid && in_ready;

  // shared compare and add of the pairing pass
  assign take    = (s >= n) || ((r < t) && (wr < w_rd));
  assign sum_add = sum + (take ? wr : w_rd);
  // length check of the depth result
  assign bad     = (w_rd == '0) || (w_rd > WW'(MAX_LENGTH));

  hclb_ram #(.WIDTH(FW), .DEPTH(ALPHABET)) u_freq (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );
  hclb_ram #(.WIDTH($bits(ent_t)), .DEPTH(ALPHABET)) u_sort (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );
  hclb_ram #(.WIDTH(WW), .DEPTH(ALPHABET)) u_work (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
  );
  hclb_ram #(.WIDTH(LW), .DEPTH(ALPHABET)) u_len (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
  );

  // memory port steering
  always_comb begin
    f_we = 1'b0; f_wa = symbol;       f_wd = frequency; f_ra = idx[AW-1:0];
    s_we = 1'b0; s_wa = n[AW-1:0];    s_wd = key;       s_ra = idx[AW-1:0];
    w_we = 1'b0; w_wa = paddr;        w_wd = '0;        w_ra = idx[AW-1:0];
    l_we = 1'b0; l_wa = idx[AW-1:0];  l_wd = '0;        l_ra = symbol;
    unique case (state)
      S_IDLE: begin
        f_we = acc && (operation == OP_LOAD);
      end
      S_CLR: begin
        // sweep the frequency store by index, and the length store too after reset
        f_we = (idx != CW'(ALPHABET));
        f_wa = idx[AW-1:0];
        f_wd = '0;
        l_we = rst_clr && (idx != CW'(ALPHABET));
      end
      S_SCAN: begin
        // append used symbols in symbol order, clear the length table
        s_we = pv && (f_rd != '0);
        s_wd = '{sym: paddr, freq: f_rd};
        l_we = (idx != CW'(ALPHABET));
      end
      S_SORT_A: s_ra = a[AW-1:0];
      S_SORT_B: s_ra = AW'(b - 1'b1);
      S_SORT_C: begin
        s_we = 1'b1;
        s_wa = b[AW-1:0];
        s_wd = (s_rd.freq > key.freq) ? s_rd : key;
      end
      S_SORT_D: begin
        s_ra = AW'(b - 1'b1);
        s_we = (b == '0);
        s_wa = b[AW-1:0];
      end
      S_COPY: begin
        w_we = pv;
        w_wd = WW'(s_rd.freq);
      end
      S_P0: w_ra = r[AW-1:0];
      S_P1: w_ra = s[AW-1:0];
      S_P2: begin
        if (take) begin
          w_we = (r < n);
          w_wa = r[AW-1:0];
          w_wd = WW'(t);
        end else begin
          w_we = (s > t);
          w_wa = s[AW-1:0];
        end
      end
      S_P3: begin
        w_we = 1'b1;
        w_wa = t[AW-1:0];
        w_wd = sum;
      end
      S_DK: w_ra = AW'(k - 1'b1);
      S_D3: begin
        w_we = (cnt > 0) && (i != '0);
        w_wa = AW'(i - 1'b1);
        w_wd = WW'(depth);
      end
      S_WR: begin
        l_we = pv;
        l_wa = s_rd.sym;
        l_wd = one ? LW'(1) : w_rd[LW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      rst_clr   <= 1'b1;
      out_valid <= 1'b0;
      n         <= '0;
      fail      <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (idx != CW'(ALPHABET)) begin
            idx <= idx + 1'b1;
          end else begin
            rst_clr <= 1'b0;
            state   <= S_IDLE;
            if (!rst_clr) begin
              // build finished report
              out_valid    <= 1'b1;
              kind         <= KIND_REPORT;
              symbol_out   <= '0;
              code_length  <= '0;
              status       <= fail;
              used_symbols <= n;
            end
          end
        end
        S_IDLE: begin
          if (acc) begin
            if (operation == OP_READ) begin
              symbol_out <= symbol;
              state      <= S_RD;
            end else if (last) begin
              idx   <= '0;
              pv    <= 1'b0;
              n     <= '0;
              fail  <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_RD: begin
          out_valid    <= 1'b1;
          kind         <= KIND_READ;
          code_length  <= l_rd;
          status       <= 1'b0;
          used_symbols <= n;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          if (pv && (f_rd != '0)) begin
            n <= n + 1'b1;
          end
          if (idx != CW'(ALPHABET)) begin
            idx   <= idx + 1'b1;
            pv    <= 1'b1;
            paddr <= idx[AW-1:0];
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              a     <= CW'(1);
              state <= S_SORT_A;
            end
          end
        end
        S_SORT_A: begin
          if (a >= n) begin
            idx <= '0;
            pv  <= 1'b0;
            one <= (n == CW'(1));
            if (n == '0) begin
              state <= S_CLR;
            end else if (n == CW'(1)) begin
              state <= S_WR;
            end else begin
              state <= S_COPY;
            end
          end else begin
            b     <= a;
            state <= S_SORT_B;
          end
        end
        S_SORT_B: begin
          key   <= s_rd;
          state <= S_SORT_C;
        end
        S_SORT_C: begin
          // stable: move only strictly larger frequencies up
          if (s_rd.freq > key.freq) begin
            b     <= b - 1'b1;
            state <= S_SORT_D;
          end else begin
            a     <= a + 1'b1;
            state <= S_SORT_A;
          end
        end
        S_SORT_D: begin
          if (b == '0) begin
            a     <= a + 1'b1;
            state <= S_SORT_A;
          end else begin
            state <= S_SORT_C;
          end
        end
        S_COPY: begin
          if (idx != n) begin
            idx   <= idx + 1'b1;
            pv    <= 1'b1;
            paddr <= idx[AW-1:0];
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              s     <= '0;
              r     <= '0;
              t     <= '0;
              kk    <= 1'b0;
              sum   <= '0;
              state <= S_P0;
            end
          end
        end
        S_P0: begin
          if (t >= n - 1'b1) begin
            top   <= n - CW'(2);
            depth <= CW'(1);
            i     <= n;
            nodes <= (CW+1)'(2);
            guard <= '0;
            state <= S_D0;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: begin
          wr    <= w_rd;
          state <= S_P2;
        end
        S_P2: begin
          sum <= sum_add;
          if (take) begin
            r <= r + 1'b1;
          end else begin
            s <= s + 1'b1;
          end
          kk    <= ~kk;
          state <= kk ? S_P3 : S_P0;
        end
        S_P3: begin
          t     <= t + 1'b1;
          sum   <= '0;
          state <= S_P0;
        end
        S_D0: begin
          if ((i != '0) && (guard <= n)) begin
            k     <= top;
            state <= S_DK;
          end else begin
            idx   <= '0;
            pv    <= 1'b0;
            state <= S_CHK;
          end
        end
        S_DK: begin
          state <= (k != '0) ? S_D1 : S_D2;
        end
        S_D1: begin
          if (w_rd >= WW'(top)) begin
            k     <= k - 1'b1;
            state <= S_DK;
          end else begin
            state <= S_D2;
          end
        end
        S_D2: begin
          inner <= top - k;
          cnt   <= $signed({1'b0, nodes}) - $signed((CW+2)'(top - k));
          state <= S_D3;
        end
        S_D3: begin
          if ((cnt > 0) && (i != '0)) begin
            i   <= i - 1'b1;
            cnt <= cnt - $signed((CW+2)'(1));
          end else begin
            nodes <= {inner, 1'b0};
            top   <= k;
            depth <= depth + 1'b1;
            guard <= guard + 1'b1;
            state <= S_D0;
          end
        end
        S_CHK: begin
          if (pv && bad) begin
            fail <= 1'b1;
          end
          if (idx != n) begin
            idx <= idx + 1'b1;
            pv  <= 1'b1;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              idx   <= '0;
              state <= fail ? S_CLR : S_WR;
            end
          end
        end
        S_WR: begin
          if (idx != n) begin
            idx <= idx + 1'b1;
            pv  <= 1'b1;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              idx   <= '0;
              state <= S_CLR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "huffman_code_length_builder_unit_assert.svh"

  // used count never exceeds the alphabet
  `HCLB_ASSERT_ALWAYS(a_used_range, clk, rst, n <= CW'(ALPHABET))
  // a read answer never carries a failure status
  `HCLB_ASSERT_IMP(a_read_status, clk, rst, out_valid && (kind == KIND_READ), !status)
  // no request is taken while a result waits or the sequencer is busy
  `HCLB_ASSERT_IMP(a_busy_ready, clk, rst, out_valid || (state != S_IDLE), !in_ready)
endmodule
`default_nettype wire
